// ===== design/slld_pkg.sv =====
// Shared types and constants for the sync-header / line deframer.
`timescale 1ns / 1ps

package slld_pkg;

  localparam int LINE_COUNT_MAX = 4095;
  localparam int SYNC_MAX       = 3;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [2:0] CFG_MODE        = 3'd0;
  localparam logic [2:0] CFG_SYNC_LEN    = 3'd1;
  localparam logic [2:0] CFG_SYNC_FIRST  = 3'd2;
  localparam logic [2:0] CFG_SYNC_SECOND = 3'd3;
  localparam logic [2:0] CFG_SYNC_THIRD  = 3'd4;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [11:0] count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ===== design/slld_front.sv =====
// Front end: configuration registers, sync hunt, phase machine and line splitting.
`timescale 1ns / 1ps

module slld_front #(
  parameter int LineCountMax = slld_pkg::LINE_COUNT_MAX,
  parameter int SyncMax      = slld_pkg::SYNC_MAX
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                q_room,
  input  logic [7:0]          in_rx_byte,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_wdata,
  output slld_pkg::push_t     push
);

  localparam int PW     = $clog2(LineCountMax + 1);
  localparam int FW     = $clog2(SyncMax + 1);
  localparam int HdrCap = (SyncMax < 3) ? SyncMax : 3;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_PAY  = 2'd2;
  localparam logic [1:0] PH_CSUM = 2'd3;

  logic          mode_r, mode_nxt;
  logic [1:0]    sync_len_r, sync_len_nxt;
  logic [7:0]    first_r, first_nxt;
  logic [7:0]    second_r, second_nxt;
  logic [7:0]    third_r, third_nxt;
  logic [7:0]    win_r [SyncMax];
  logic [7:0]    win_nxt [SyncMax];
  logic [FW-1:0] fill_r, fill_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [7:0]    left_r, left_nxt;
  logic [PW-1:0] seen_r, seen_nxt;
  logic          cr_r, cr_nxt;

  logic          step;
  logic [1:0]    hdr_n;
  logic          match;
  logic [PW-1:0] seen_one;
  logic          clear;

  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] s);
    return (s < PW'(LineCountMax)) ? s + PW'(1) : s;
  endfunction

  assign step = in_valid && q_room;

  always_comb begin
    hdr_n = (sync_len_r < 2'd2) ? 2'd2 : sync_len_r;
    if (hdr_n > 2'(HdrCap)) begin
      hdr_n = 2'(HdrCap);
    end
    if (hdr_n == 2'd3) begin
      match = (win_r[1] == first_r) && (win_r[0] == second_r) && (in_rx_byte == third_r);
    end else begin
      match = (win_r[0] == first_r) && (in_rx_byte == second_r);
    end
  end

  always_comb begin
    mode_nxt     = mode_r;
    sync_len_nxt = sync_len_r;
    first_nxt    = first_r;
    second_nxt   = second_r;
    third_nxt    = third_r;
    win_nxt      = win_r;
    fill_nxt     = fill_r;
    phase_nxt    = phase_r;
    left_nxt     = left_r;
    seen_nxt     = seen_r;
    cr_nxt       = cr_r;
    push         = '0;
    clear        = 1'b0;
    seen_one     = cr_r ? sat_inc(seen_r) : seen_r;

    if (step) begin
      if (mode_r) begin
        if (cr_r && (in_rx_byte == slld_pkg::CH_LF)) begin
          push.num = 2'd1;
          push.r0  = '{slld_pkg::KIND_END, 8'd0, 12'(seen_r), 1'b1};
          seen_nxt = '0;
          cr_nxt   = 1'b0;
        end else if (in_rx_byte == slld_pkg::CH_CR) begin
          cr_nxt   = 1'b1;
          seen_nxt = seen_one;
          if (cr_r) begin
            push.num = 2'd1;
            push.r0  = '{slld_pkg::KIND_PAYLOAD, slld_pkg::CH_CR, 12'd0, 1'b1};
          end
        end else begin
          cr_nxt   = 1'b0;
          seen_nxt = sat_inc(seen_one);
          if (cr_r) begin
            push.num = 2'd2;
            push.r0  = '{slld_pkg::KIND_PAYLOAD, slld_pkg::CH_CR, 12'd0, 1'b0};
            push.r1  = '{slld_pkg::KIND_PAYLOAD, in_rx_byte, 12'd0, 1'b1};
          end else begin
            push.num = 2'd1;
            push.r0  = '{slld_pkg::KIND_PAYLOAD, in_rx_byte, 12'd0, 1'b1};
          end
        end
      end else begin
        case (phase_r)
          PH_HUNT: begin
            for (int i = SyncMax - 1; i > 0; i--) begin
              win_nxt[i] = win_r[i-1];
            end
            win_nxt[0] = in_rx_byte;
            if (fill_r < FW'(SyncMax)) begin
              fill_nxt = fill_r + FW'(1);
            end
            if ((fill_nxt >= FW'(hdr_n)) && match) begin
              for (int i = 0; i < SyncMax; i++) begin
                win_nxt[i] = 8'd0;
              end
              fill_nxt  = '0;
              phase_nxt = PH_LEN;
            end
          end
          PH_LEN: begin
            if (in_rx_byte == 8'd0) begin
              clear    = 1'b1;
              push.num = 2'd1;
              push.r0  = '{slld_pkg::KIND_ERROR, 8'd0, 12'd0, 1'b1};
            end else begin
              left_nxt  = in_rx_byte - 8'd1;
              seen_nxt  = '0;
              phase_nxt = (in_rx_byte == 8'd1) ? PH_CSUM : PH_PAY;
            end
          end
          PH_PAY: begin
            push.num = 2'd1;
            push.r0  = '{slld_pkg::KIND_PAYLOAD, in_rx_byte, 12'd0, 1'b1};
            seen_nxt = seen_r + PW'(1);
            left_nxt = left_r - 8'd1;
            if (left_r == 8'd1) begin
              phase_nxt = PH_CSUM;
            end
          end
          default: begin
            push.num = 2'd1;
            push.r0  = '{slld_pkg::KIND_END, in_rx_byte, 12'(seen_r), 1'b1};
            clear    = 1'b1;
          end
        endcase
      end
    end

    if (cfg_valid) begin
      case (cfg_index)
        slld_pkg::CFG_MODE: begin
          if (cfg_wdata[0] != mode_r) begin
            clear = 1'b1;
          end
          mode_nxt = cfg_wdata[0];
        end
        slld_pkg::CFG_SYNC_LEN:    sync_len_nxt = cfg_wdata[1:0];
        slld_pkg::CFG_SYNC_FIRST:  first_nxt    = cfg_wdata;
        slld_pkg::CFG_SYNC_SECOND: second_nxt   = cfg_wdata;
        slld_pkg::CFG_SYNC_THIRD:  third_nxt    = cfg_wdata;
        default: ;
      endcase
    end

    if (clear) begin
      for (int i = 0; i < SyncMax; i++) begin
        win_nxt[i] = 8'd0;
      end
      fill_nxt  = '0;
      phase_nxt = PH_HUNT;
      left_nxt  = 8'd0;
      seen_nxt  = '0;
      cr_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      sync_len_r <= 2'd2;
      first_r    <= 8'd0;
      second_r   <= 8'd0;
      third_r    <= 8'd0;
      for (int i = 0; i < SyncMax; i++) begin
        win_r[i] <= 8'd0;
      end
      fill_r     <= '0;
      phase_r    <= PH_HUNT;
      left_r     <= 8'd0;
      seen_r     <= '0;
      cr_r       <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      sync_len_r <= sync_len_nxt;
      first_r    <= first_nxt;
      second_r   <= second_nxt;
      third_r    <= third_nxt;
      win_r      <= win_nxt;
      fill_r     <= fill_nxt;
      phase_r    <= phase_nxt;
      left_r     <= left_nxt;
      seen_r     <= seen_nxt;
      cr_r       <= cr_nxt;
    end
  end

endmodule

// ===== design/slld_queue.sv =====
// Short result queue between the front end and the output stage, two writes and one read.
`timescale 1ns / 1ps

module slld_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  slld_pkg::push_t   push,
  input  logic              pop,
  output logic              room,
  output logic              head_valid,
  output slld_pkg::result_t head
);

  localparam int AW = slld_pkg::Q_AW;

  slld_pkg::result_t q_r [slld_pkg::Q_DEPTH];
  logic [AW-1:0]     wptr_r, wptr_nxt;
  logic [AW-1:0]     rptr_r, rptr_nxt;
  logic [AW:0]       cnt_r, cnt_nxt;

  assign room       = cnt_r <= (AW + 1)'(slld_pkg::Q_DEPTH - 2);
  assign head_valid = cnt_r != '0;
  assign head       = q_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r + AW'(push.num);
    rptr_nxt = rptr_r + AW'(pop);
    cnt_nxt  = cnt_r + (AW + 1)'(push.num) - (AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      q_r[wptr_r] <= push.r0;
    end
    if (push.num == 2'd2) begin
      q_r[wptr_r + AW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== design/slld_back.sv =====
// Output stage: registers one result at a time from the queue and holds it under backpressure.
`timescale 1ns / 1ps

module slld_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  slld_pkg::result_t head,
  output logic              pop,
  input  logic              out_ready,
  output logic              out_valid,
  output slld_pkg::result_t out_res
);

  logic              valid_r, valid_nxt;
  slld_pkg::result_t res_r, res_nxt;
  logic              load;

  assign load      = !valid_r || out_ready;
  assign pop       = head_valid && load;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = load ? head_valid : valid_r;
    res_nxt   = pop ? head : res_r;
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

// ===== design/sync_length_or_line_deframer.sv =====
// Top level of the deframer: front end, result queue and output stage.
// A result is queued as its byte is accepted and is then registered in the output stage.
// Throughput: one byte per cycle while the four-entry result queue has room for two results.
// CR then a non-CR, non-LF byte gives two results, drained one per cycle unless stalled.
// Reset (synchronous, active low) empties the queue and output stage and returns all
// deframing state and configuration registers to their reset values.
`timescale 1ns / 1ps

module sync_length_or_line_deframer #(
  parameter int LineCountMax = slld_pkg::LINE_COUNT_MAX,
  parameter int SyncMax      = slld_pkg::SYNC_MAX
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [11:0] out_frame_count,
  output logic        out_run_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  slld_pkg::push_t   push;
  slld_pkg::result_t head;
  slld_pkg::result_t out_res;
  logic              room;
  logic              head_valid;
  logic              pop;

  assign in_ready  = room;
  assign cfg_ready = 1'b1;

  slld_front #(
    .LineCountMax(LineCountMax),
    .SyncMax     (SyncMax)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .q_room    (room),
    .in_rx_byte(in_rx_byte),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push)
  );

  slld_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .room      (room),
    .head_valid(head_valid),
    .head      (head)
  );

  slld_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind        = out_res.kind;
  assign out_byte        = out_res.data;
  assign out_frame_count = out_res.count;
  assign out_run_last    = out_res.last;

endmodule

// ===== design/slld_checker.sv =====
// Port-level checks on the deframer, bound to the top level.
`timescale 1ns / 1ps

module slld_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_byte,
  input logic [11:0] out_frame_count,
  input logic        out_run_last
);

  a_reset_clears_output: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(out_frame_count) && $stable(out_run_last))
    else $error("stalled transaction changed");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind == slld_pkg::KIND_PAYLOAD || out_kind == slld_pkg::KIND_END
      || out_kind == slld_pkg::KIND_ERROR)
    else $error("illegal result kind");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == slld_pkg::KIND_ERROR |->
      out_run_last && out_byte == 8'd0 && out_frame_count == 12'd0)
    else $error("malformed error result");

  a_payload_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == slld_pkg::KIND_PAYLOAD |-> out_frame_count == 12'd0)
    else $error("payload result carries a count");

endmodule

bind sync_length_or_line_deframer slld_checker u_slld_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_kind       (out_kind),
  .out_byte       (out_byte),
  .out_frame_count(out_frame_count),
  .out_run_last   (out_run_last)
);

// ===== tb/sv/sync_length_or_line_deframer_tb.sv =====
// Self-checking testbench for the sync-header / CR LF line deframer.
`timescale 1ns / 1ps

module sync_length_or_line_deframer_tb;

  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_BYTES = 500;

  typedef enum logic [1:0] {HUNT, GET_LEN, IN_PAYLOAD, GET_CSUM} stage_t;

  typedef struct packed {
    logic              is_cfg;
    logic [2:0]        idx;
    logic [7:0]        val;
    logic              typed;
    slld_pkg::result_t want;
  } step_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [11:0] out_frame_count;
  logic        out_run_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [7:0]  cfg_wdata = 8'h00;

  sync_length_or_line_deframer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_frame_count (out_frame_count),
    .out_run_last    (out_run_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  slld_pkg::result_t pending_results[$];
  slld_pkg::result_t head;
  int          errors = 0;
  int          bytes_in = 0;
  int          quiet = 0;
  int          stall_left = 0;
  logic        held_long = 1'b0;
  logic        calm_out = 1'b0;
  logic        calm_in = 1'b0;

  logic        line_mode;
  logic [1:0]  hdr_len_reg;
  logic [7:0]  sync_pat[3];
  logic [7:0]  window[3];
  int          window_fill;
  stage_t      stage;
  int          bytes_left;
  int          payload_seen;
  logic        cr_held;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic slld_pkg::result_t res(logic [1:0] k, logic [7:0] d, logic [11:0] c,
                                            logic l);
    slld_pkg::result_t r;
    r.kind = k;
    r.data = d;
    r.count = c;
    r.last = l;
    return r;
  endfunction

  function automatic void add_result(logic [1:0] k, logic [7:0] d, int c, logic l);
    pending_results.push_back(res(k, d, 12'(c), l));
  endfunction

  function automatic void clear_frame();
    window = '{8'h00, 8'h00, 8'h00};
    window_fill = 0;
    stage = HUNT;
    bytes_left = 0;
    payload_seen = 0;
    cr_held = 1'b0;
  endfunction

  function automatic int header_bytes();
    if (hdr_len_reg < 2) return 2;
    if (hdr_len_reg > slld_pkg::SYNC_MAX) return slld_pkg::SYNC_MAX;
    return int'(hdr_len_reg);
  endfunction

  function automatic void count_line_byte();
    if (payload_seen < slld_pkg::LINE_COUNT_MAX) payload_seen++;
  endfunction

  function automatic void line_step(logic [7:0] b);
    if (cr_held) begin
      cr_held = 1'b0;
      if (b == slld_pkg::CH_LF) begin
        add_result(slld_pkg::KIND_END, 8'h00, payload_seen, 1'b1);
        payload_seen = 0;
        return;
      end
      add_result(slld_pkg::KIND_PAYLOAD, slld_pkg::CH_CR, 0, b == slld_pkg::CH_CR);
      count_line_byte();
    end
    if (b == slld_pkg::CH_CR) begin
      cr_held = 1'b1;
      return;
    end
    add_result(slld_pkg::KIND_PAYLOAD, b, 0, 1'b1);
    count_line_byte();
  endfunction

  function automatic void binary_step(logic [7:0] b);
    int n;
    logic hit;
    case (stage)
      HUNT: begin
        window[2] = window[1];
        window[1] = window[0];
        window[0] = b;
        if (window_fill < slld_pkg::SYNC_MAX) window_fill++;
        n = header_bytes();
        if (window_fill >= n) begin
          hit = 1'b1;
          for (int i = 0; i < n; i++) if (window[n - 1 - i] != sync_pat[i]) hit = 1'b0;
          if (hit) begin
            window = '{8'h00, 8'h00, 8'h00};
            window_fill = 0;
            stage = GET_LEN;
          end
        end
      end
      GET_LEN: begin
        if (b == 8'h00) begin
          clear_frame();
          add_result(slld_pkg::KIND_ERROR, 8'h00, 0, 1'b1);
        end else begin
          bytes_left = int'(b) - 1;
          payload_seen = 0;
          stage = (bytes_left == 0) ? GET_CSUM : IN_PAYLOAD;
        end
      end
      IN_PAYLOAD: begin
        add_result(slld_pkg::KIND_PAYLOAD, b, 0, 1'b1);
        payload_seen++;
        bytes_left--;
        if (bytes_left == 0) stage = GET_CSUM;
      end
      default: begin
        add_result(slld_pkg::KIND_END, b, payload_seen, 1'b1);
        clear_frame();
      end
    endcase
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    if (line_mode) line_step(b);
    else binary_step(b);
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [7:0] val);
    case (idx)
      slld_pkg::CFG_MODE: begin
        if (val[0] != line_mode) clear_frame();
        line_mode = val[0];
      end
      slld_pkg::CFG_SYNC_LEN:    hdr_len_reg = val[1:0];
      slld_pkg::CFG_SYNC_FIRST:  sync_pat[0] = val;
      slld_pkg::CFG_SYNC_SECOND: sync_pat[1] = val;
      slld_pkg::CFG_SYNC_THIRD:  sync_pat[2] = val;
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_in) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_sync();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic step_t feed(logic [7:0] b);
    step_t s;
    s = '0;
    s.val = b;
    return s;
  endfunction

  function automatic step_t feed_exp(logic [7:0] b, slld_pkg::result_t r);
    step_t s;
    s = feed(b);
    s.typed = 1'b1;
    s.want = r;
    return s;
  endfunction

  function automatic step_t set_reg(logic [2:0] idx, logic [7:0] v);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.val = v;
    return s;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_in++;
    deframe_byte(b);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, val);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_setup(input int k);
    settle();
    calm_in = ($urandom_range(0, 3) == 0);
    cfg_write(slld_pkg::CFG_MODE, {7'($urandom), 1'($urandom_range(0, 2) == 0)});
    cfg_write(slld_pkg::CFG_SYNC_LEN, {6'($urandom), 2'(k)});
    cfg_write(slld_pkg::CFG_SYNC_FIRST, pick_sync());
    cfg_write(slld_pkg::CFG_SYNC_SECOND, pick_sync());
    cfg_write(slld_pkg::CFG_SYNC_THIRD, pick_sync());
    if ($urandom_range(0, 3) == 0) cfg_write(3'($urandom_range(5, 7)), 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic binary_frames(input int target);
    int start;
    int n;
    int len;
    int r;
    start = bytes_in;
    n = header_bytes();
    while (bytes_in - start < target) begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < $urandom_range(1, n - 1); i++) send_byte(sync_pat[i]);
      end else begin
        for (int i = 0; i < n; i++) send_byte(sync_pat[i]);
        r = $urandom_range(0, 39);
        if (r < 3) len = 0;
        else if (r < 7) len = 1;
        else if (r == 7) len = $urandom_range(128, 255);
        else len = $urandom_range(2, 10);
        send_byte(8'(len));
        if (len > 0) repeat (len) send_byte(8'($urandom));
      end
    end
  endtask

  task automatic text_lines(input int target);
    int start;
    logic [7:0] b;
    start = bytes_in;
    while (bytes_in - start < target) begin
      repeat ($urandom_range(0, 12)) begin
        b = 8'($urandom);
        if ($urandom_range(0, 7) == 0) b = slld_pkg::CH_CR;
        send_byte(b);
      end
      if ($urandom_range(0, 9) != 0) begin
        send_byte(slld_pkg::CH_CR);
        send_byte(slld_pkg::CH_LF);
      end
    end
  endtask

  function automatic void field_ok(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: kind %0d, byte %0d", out_kind, out_byte);
          errors++;
        end else begin
          head = pending_results.pop_front();
          field_ok("out_kind", 12'(head.kind), 12'(out_kind));
          field_ok("out_byte", 12'(head.data), 12'(out_byte));
          field_ok("out_frame_count", head.count, out_frame_count);
          field_ok("out_run_last", 12'(head.last), 12'(out_run_last));
        end
      end
      if ($urandom_range(0, 63) == 0) calm_out <= ~calm_out;
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (!held_long && bytes_in >= 250) begin
        held_long <= 1'b1;
        stall_left <= 120;
        out_ready <= 1'b0;
      end else if (!calm_out && $urandom_range(0, 3) == 0) begin
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    step_t plan[$];
    logic  cfg_open;
    int    k;
    int    base;

    line_mode = 1'b0;
    hdr_len_reg = 2'd2;
    sync_pat = '{8'h00, 8'h00, 8'h00};
    clear_frame();
    cfg_open = 1'b0;

    plan = '{
      feed(8'h00), feed(8'h00),
      feed_exp(8'h00, res(slld_pkg::KIND_ERROR, 8'h00, 12'd0, 1'b1)),
      feed(8'h00), feed(8'h00), feed(8'h01),
      feed_exp(8'hFF, res(slld_pkg::KIND_END, 8'hFF, 12'd0, 1'b1)),
      set_reg(slld_pkg::CFG_SYNC_LEN, 8'h03), set_reg(slld_pkg::CFG_SYNC_FIRST, 8'hFF),
      set_reg(slld_pkg::CFG_SYNC_SECOND, 8'h00), set_reg(slld_pkg::CFG_SYNC_THIRD, 8'hA5),
      feed(8'hFF), feed(8'h00), feed(8'hA5), feed(8'h03),
      feed(8'h00), feed(8'hFF), feed(8'h7E),
      set_reg(slld_pkg::CFG_MODE, 8'h01),
      feed(8'h41), feed(slld_pkg::CH_CR), feed(8'h42), feed(slld_pkg::CH_CR),
      feed_exp(slld_pkg::CH_LF, res(slld_pkg::KIND_END, 8'h00, 12'd3, 1'b1)),
      feed(slld_pkg::CH_LF), feed(slld_pkg::CH_CR), feed(slld_pkg::CH_CR),
      feed(slld_pkg::CH_LF)
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!cfg_open) settle();
        cfg_write(plan[i].idx, plan[i].val);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_valid <= 1'b0;
        cfg_open = 1'b0;
        send_byte(plan[i].val);
        if (plan[i].typed) begin
          void'(pending_results.pop_back());
          pending_results.push_back(plan[i].want);
        end
      end
    end

    base = bytes_in;
    k = 0;
    while (bytes_in - base < RANDOM_BYTES) begin
      random_setup(k);
      if (line_mode) text_lines($urandom_range(30, 80));
      else binary_frames($urandom_range(30, 80));
      k++;
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
